### rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: widths, codes, state type, table entry.
// No dependencies.
package ffha_pkg;
    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int HEADER_BYTES = 24;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [31:0] BASE_RESET = 32'h2040_0000;
    localparam logic [31:0] LIMIT_RESET = 32'd2097152;
    localparam int ENTRY_W = 65;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SREAD,   // issue read of entry at scan index
        S_SCHECK,  // compare read data
        S_GROW,
        S_SHUP_RD, // shift up: read entry k-1
        S_SHUP_WR,
        S_SPLIT,
        S_MERGE_RD,
        S_MERGE_CK,
        S_SHDN_RD,
        S_SHDN_WR,
        S_DONE
    } state_t;
endpackage

### rtl/ffha_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on nothing.
interface ffha_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
    modport source (output valid, command, request_bytes, release_address, input ready);
    modport sink (input valid, command, request_bytes, release_address, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] granted_address;
    logic [1:0]  status;
    modport source (output valid, granted_address, status, input ready);
    modport sink (input valid, granted_address, status, output ready);
endinterface

### rtl/ffha_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, block table RAM, break pointer.
// Depends on ffha_pkg, ffha_if, ffha_ram.
//
//  channel   dir   handshake      payload
//  cmd       in    valid/ready    command, request_bytes, release_address
//  rsp       out   valid/ready    granted_address, status
//  cfg       in    cfg_we         cfg_index, cfg_data
//
// One item at a time. The table lives in a single-port RAM; the first-fit scan
// reads and checks each entry visited, and an insert or remove shift reads and
// writes each entry moved before the result is made valid.
// rst_n resets state, count, break, base, limit and result valid at once; no clearing pass is needed.
// The result register is held until taken; no new item is accepted until then.
module first_fit_heap_allocator (
    input  logic        clk,
    input  logic        rst_n,
    ffha_cmd_if.sink    cmd,
    ffha_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    ffha_pkg::state_t state_reg, state_next;
    logic [31:0] base_reg, limit_reg, brk_reg, brk_next;
    logic [ffha_pkg::CNT_W-1:0] count_reg, count_next;
    logic [ffha_pkg::CNT_W-1:0] idx_reg, idx_next;   // scan index / found slot
    logic [ffha_pkg::CNT_W-1:0] k_reg, k_next;       // shift pointer
    logic        cmd_reg;
    logic [32:0] sz_reg;                             // rounded size, 33 bits, no wrap
    logic [31:0] addr_reg;
    ffha_pkg::entry_t hit_reg, hit_next;             // copy of found entry
    logic [31:0] gaddr_reg, gaddr_next;
    logic [1:0]  status_reg, status_next;
    logic        rvalid_reg;

    logic        ram_we;
    logic [ffha_pkg::IDX_W-1:0] ram_addr;
    ffha_pkg::entry_t ram_wdata, ram_rdata;
    ffha_pkg::entry_t mv_reg;                        // found entry as read

    ffha_ram #(.WIDTH(ffha_pkg::ENTRY_W), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic logic [ffha_pkg::IDX_W-1:0] IDXM1(input logic [ffha_pkg::CNT_W-1:0] v);
        logic [ffha_pkg::CNT_W-1:0] t;
        t = v - 1'b1;
        return t[ffha_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [ffha_pkg::IDX_W-1:0] IDXP1(input logic [ffha_pkg::CNT_W-1:0] v);
        logic [ffha_pkg::CNT_W-1:0] t;
        t = v + 1'b1;
        return t[ffha_pkg::IDX_W-1:0];
    endfunction

    logic accept;
    assign accept = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ffha_pkg::S_IDLE) && !rvalid_reg;
    assign rsp.valid = rvalid_reg;
    assign rsp.granted_address = gaddr_reg;
    assign rsp.status = status_reg;

    // shared arithmetic
    logic [33:0] rem_need;      // sz + header + 8
    logic [32:0] hdr_addr;
    logic [33:0] need;
    logic [33:0] grow;
    logic [33:0] nbrk;
    logic [32:0] wend;
    logic [32:0] end_sat;
    logic [32:0] merged;
    assign rem_need = {1'b0, sz_reg} + 34'(ffha_pkg::HEADER_BYTES + 8);
    assign hdr_addr = {1'b0, ram_rdata.start} + 33'(ffha_pkg::HEADER_BYTES);
    assign need = {1'b0, sz_reg} + 34'(ffha_pkg::HEADER_BYTES + ffha_pkg::PAGE_BYTES - 1);
    assign grow = {need[33:ffha_pkg::PAGE_SHIFT], {ffha_pkg::PAGE_SHIFT{1'b0}}};
    assign nbrk = {2'b0, brk_reg} + grow;
    assign wend = {1'b0, base_reg} + {1'b0, limit_reg};
    assign end_sat = wend[32] ? 33'h0_FFFF_FFFF : wend;
    assign merged = {1'b0, hit_reg.size} + 33'(ffha_pkg::HEADER_BYTES)
                  + {1'b0, ram_rdata.size};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
                if (accept)
                begin
                    if (cmd.command == ffha_pkg::CMD_ALLOC ? cmd.request_bytes == '0
                                                           : cmd.release_address == '0)
                        state_next = ffha_pkg::S_DONE;
                    else if (count_reg == '0)
                        state_next = cmd.command == ffha_pkg::CMD_ALLOC ?
                                     ffha_pkg::S_GROW : ffha_pkg::S_DONE;
                    else
                        state_next = ffha_pkg::S_SREAD;
                end
            ffha_pkg::S_SREAD:    state_next = ffha_pkg::S_SCHECK;
            ffha_pkg::S_SCHECK:
            begin
                priority if (cmd_reg == ffha_pkg::CMD_ALLOC)
                begin
                    if (ram_rdata.free && {1'b0, ram_rdata.size} >= sz_reg)
                        state_next = ({2'b0, ram_rdata.size} >= rem_need &&
                                      count_reg < ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS)) ?
                                     ffha_pkg::S_SHUP_RD : ffha_pkg::S_DONE;
                    else if (idx_reg + 1'b1 >= count_reg)
                        state_next = ffha_pkg::S_GROW;
                    else
                        state_next = ffha_pkg::S_SREAD;
                end
                else
                begin
                    if (hdr_addr[31:0] == addr_reg)
                        state_next = (idx_reg + 1'b1 < count_reg) ?
                                     ffha_pkg::S_MERGE_RD : ffha_pkg::S_DONE;
                    else if (idx_reg + 1'b1 >= count_reg)
                        state_next = ffha_pkg::S_DONE;
                    else
                        state_next = ffha_pkg::S_SREAD;
                end
            end
            ffha_pkg::S_GROW:     state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_SHUP_RD:
                state_next = (k_reg > idx_reg + 1'b1) ? ffha_pkg::S_SHUP_WR : ffha_pkg::S_SPLIT;
            ffha_pkg::S_SHUP_WR:  state_next = ffha_pkg::S_SHUP_RD;
            ffha_pkg::S_SPLIT:    state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_MERGE_RD: state_next = ffha_pkg::S_MERGE_CK;
            ffha_pkg::S_MERGE_CK:
                state_next = ram_rdata.free ? ffha_pkg::S_SHDN_RD : ffha_pkg::S_DONE;
            ffha_pkg::S_SHDN_RD:
                state_next = (k_reg + 1'b1 < count_reg) ? ffha_pkg::S_SHDN_WR : ffha_pkg::S_DONE;
            ffha_pkg::S_SHDN_WR:  state_next = ffha_pkg::S_SHDN_RD;
            ffha_pkg::S_DONE:     state_next = ffha_pkg::S_IDLE;
            default:              state_next = ffha_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = idx_reg[ffha_pkg::IDX_W-1:0];
        ram_wdata = hit_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        hit_next = hit_reg;
        gaddr_next = gaddr_reg;
        status_next = status_reg;
        count_next = count_reg;
        brk_next = brk_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
                if (accept)
                begin
                    idx_next = '0;
                    gaddr_next = '0;
                    if (cmd.command == ffha_pkg::CMD_ALLOC)
                        status_next = cmd.request_bytes == '0 ? ffha_pkg::ST_NULL
                                                              : ffha_pkg::ST_OK;
                    else
                        status_next = cmd.release_address == '0 ? ffha_pkg::ST_NULL
                                    : (count_reg == '0 ? ffha_pkg::ST_UNKNOWN
                                                       : ffha_pkg::ST_OK);
                end
            ffha_pkg::S_SREAD:
                ram_addr = idx_reg[ffha_pkg::IDX_W-1:0];
            ffha_pkg::S_SCHECK:
            begin
                hit_next = ram_rdata;
                if (cmd_reg == ffha_pkg::CMD_ALLOC)
                begin
                    if (ram_rdata.free && {1'b0, ram_rdata.size} >= sz_reg)
                    begin
                        gaddr_next = hdr_addr[31:0];
                        k_next = count_reg;
                        ram_we = 1'b1;
                        ram_wdata = ram_rdata;
                        ram_wdata.free = 1'b0;
                        if ({2'b0, ram_rdata.size} >= rem_need &&
                            count_reg < ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS))
                        begin
                            // found block shrinks in place; remainder goes in at S_SPLIT
                            ram_wdata.size = sz_reg[31:0];
                            hit_next.size = sz_reg[31:0];
                            hit_next.free = 1'b0;
                        end
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (hdr_addr[31:0] == addr_reg)
                    begin
                        ram_we = 1'b1;
                        ram_wdata = ram_rdata;
                        ram_wdata.free = 1'b1;
                        hit_next.free = 1'b1;
                        k_next = idx_reg + 1'b1;
                    end
                    else if (idx_reg + 1'b1 >= count_reg)
                        status_next = ffha_pkg::ST_UNKNOWN;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ffha_pkg::S_GROW:
            begin
                if (count_reg >= ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS) || grow == '0 ||
                    nbrk > {1'b0, end_sat})
                    status_next = ffha_pkg::ST_NOMEM;
                else
                begin
                    ram_we = 1'b1;
                    ram_addr = count_reg[ffha_pkg::IDX_W-1:0];
                    ram_wdata.start = brk_reg;
                    ram_wdata.size = sz_reg[31:0];
                    ram_wdata.free = 1'b0;
                    gaddr_next = brk_reg + 32'(ffha_pkg::HEADER_BYTES);
                    brk_next = nbrk[31:0];
                    count_next = count_reg + 1'b1;
                end
            end
            ffha_pkg::S_SHUP_RD:
                ram_addr = IDXM1(k_reg);
            ffha_pkg::S_SHUP_WR:
            begin
                // entry k-1 read in the previous cycle moves up to k
                ram_we = 1'b1;
                ram_addr = k_reg[ffha_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
                k_next = k_reg - 1'b1;
            end
            ffha_pkg::S_SPLIT:
            begin
                // new free remainder at idx+1
                ram_we = 1'b1;
                ram_addr = IDXP1(idx_reg);
                ram_wdata.start = gaddr_reg + sz_reg[31:0];
                ram_wdata.size = mv_reg.size - sz_reg[31:0] - 32'(ffha_pkg::HEADER_BYTES);
                ram_wdata.free = 1'b1;
                count_next = count_reg + 1'b1;
            end
            ffha_pkg::S_MERGE_RD:
                ram_addr = k_reg[ffha_pkg::IDX_W-1:0];
            ffha_pkg::S_MERGE_CK:
                if (ram_rdata.free)
                begin
                    ram_we = 1'b1;
                    ram_wdata = hit_reg;
                    ram_wdata.size = merged[32] ? 32'hFFFF_FFFF : merged[31:0];
                end
            ffha_pkg::S_SHDN_RD:
                if (k_reg + 1'b1 < count_reg)
                    ram_addr = IDXP1(k_reg);
                else
                    count_next = count_reg - 1'b1;
            ffha_pkg::S_SHDN_WR:
            begin
                ram_we = 1'b1;
                ram_addr = k_reg[ffha_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
                k_next = k_reg + 1'b1;
            end
            ffha_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_IDLE;
            base_reg <= ffha_pkg::BASE_RESET;
            limit_reg <= ffha_pkg::LIMIT_RESET;
            brk_reg <= ffha_pkg::BASE_RESET;
            count_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            // base write with an empty table drags the break along
            if (cfg_we && cfg_index == ffha_pkg::CFG_BASE && count_reg == '0)
                brk_reg <= cfg_data;
            else
                brk_reg <= brk_next;
            if (cfg_we)
            begin
                if (cfg_index == ffha_pkg::CFG_BASE)
                    base_reg <= cfg_data;
                else
                    limit_reg <= cfg_data;
            end
            if (state_reg == ffha_pkg::S_DONE)
                rvalid_reg <= 1'b1;
            else if (rsp.ready)
                rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        k_reg <= k_next;
        hit_reg <= hit_next;
        gaddr_reg <= gaddr_next;
        status_reg <= status_next;
        if (state_reg == ffha_pkg::S_SCHECK)
            mv_reg <= ram_rdata;
        if (accept)
        begin
            cmd_reg <= cmd.command;
            addr_reg <= cmd.release_address;
            sz_reg <= ({1'b0, cmd.request_bytes} + 33'd7) & ~33'd7;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> state_reg == ffha_pkg::S_IDLE)
        else $error("ready outside idle");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS))
        else $error("block count overflow");
    a_rsp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == ffha_pkg::S_DONE)
        else $error("result without completion");
`endif
endmodule

### sim/tb_first_fit_heap_allocator.sv
// Testbench for first_fit_heap_allocator: directed and random allocate/release items,
// checked against an in-bench model of the block table. Needs ffha_pkg, ffha_if and first_fit_heap_allocator.
module tb_first_fit_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        command;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
        bit          pick_block;   // release address taken from the live table
        bit          skew;         // ...and then moved off the block start
        int unsigned sel;
    } heap_cmd_t;

    typedef struct {
        logic [31:0] granted_address;
        logic [1:0]  status;
    } heap_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = ffha_pkg::CFG_BASE;
    logic [31:0] cfg_data = '0;

    ffha_cmd_if cmd_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the allocator
    logic [31:0] tbl_start [ffha_pkg::MAX_BLOCKS];
    logic [31:0] tbl_size [ffha_pkg::MAX_BLOCKS];
    bit          tbl_free [ffha_pkg::MAX_BLOCKS];
    int          tbl_count;
    logic [31:0] brk;
    logic [31:0] base_reg;
    logic [31:0] limit_reg;

    heap_cmd_t   pending_cmds [$];
    heap_rsp_t   due_rsps [$];
    heap_cmd_t   cur_cmd;
    bit          cmd_taken = 0;
    int          errors = 0;
    int          n_grants = 0;
    int          n_release_ok = 0;
    int          n_refused = 0;

    function automatic void write_shadow_reg(logic idx, logic [31:0] val);
        if (idx == ffha_pkg::CFG_BASE)
        begin
            base_reg = val;
            if (tbl_count == 0)
                brk = val;
        end
        else
            limit_reg = val;
    endfunction

    function automatic heap_rsp_t do_allocate(logic [31:0] req);
        heap_rsp_t   r;
        logic [63:0] sz, have, need, grow, nbrk, top;
        int          i;
        r.granted_address = '0;
        r.status = ffha_pkg::ST_OK;
        if (req == 0)
        begin
            r.status = ffha_pkg::ST_NULL;
            return r;
        end
        sz = ({32'd0, req} + 64'd7) & ~64'd7;
        for (i = 0; i < tbl_count; i++)
        begin
            if (tbl_free[i] && {32'd0, tbl_size[i]} >= sz)
            begin
                have = {32'd0, tbl_size[i]};
                if (have >= sz + ffha_pkg::HEADER_BYTES + 8 &&
                    tbl_count < ffha_pkg::MAX_BLOCKS)
                begin
                    for (int k = tbl_count; k > i + 1; k--)
                    begin
                        tbl_start[k] = tbl_start[k-1];
                        tbl_size[k] = tbl_size[k-1];
                        tbl_free[k] = tbl_free[k-1];
                    end
                    tbl_count++;
                    tbl_start[i+1] = tbl_start[i] + ffha_pkg::HEADER_BYTES + sz[31:0];
                    tbl_size[i+1] = 32'(have - sz - ffha_pkg::HEADER_BYTES);
                    tbl_free[i+1] = 1;
                    tbl_size[i] = sz[31:0];
                end
                tbl_free[i] = 0;
                r.granted_address = tbl_start[i] + ffha_pkg::HEADER_BYTES;
                return r;
            end
        end
        if (tbl_count >= ffha_pkg::MAX_BLOCKS)
        begin
            r.status = ffha_pkg::ST_NOMEM;
            return r;
        end
        need = sz + ffha_pkg::HEADER_BYTES;
        grow = ((need + ffha_pkg::PAGE_BYTES - 1) / ffha_pkg::PAGE_BYTES)
             * ffha_pkg::PAGE_BYTES;
        nbrk = {32'd0, brk} + grow;
        top = {32'd0, base_reg} + {32'd0, limit_reg};
        if (top > 64'hFFFF_FFFF)
            top = 64'hFFFF_FFFF;
        if (grow == 0 || nbrk > top)
        begin
            r.status = ffha_pkg::ST_NOMEM;
            return r;
        end
        tbl_start[tbl_count] = brk;
        tbl_size[tbl_count] = sz[31:0];
        tbl_free[tbl_count] = 0;
        tbl_count++;
        r.granted_address = brk + ffha_pkg::HEADER_BYTES;
        brk = nbrk[31:0];
        return r;
    endfunction

    function automatic heap_rsp_t do_release(logic [31:0] addr);
        heap_rsp_t   r;
        logic [63:0] merged;
        int          i;
        r.granted_address = '0;
        r.status = ffha_pkg::ST_OK;
        if (addr == 0)
        begin
            r.status = ffha_pkg::ST_NULL;
            return r;
        end
        for (i = 0; i < tbl_count; i++)
            if (tbl_start[i] + ffha_pkg::HEADER_BYTES == addr)
                break;
        if (i >= tbl_count)
        begin
            r.status = ffha_pkg::ST_UNKNOWN;
            return r;
        end
        tbl_free[i] = 1;
        if (i + 1 < tbl_count && tbl_free[i+1])
        begin
            merged = {32'd0, tbl_size[i]} + ffha_pkg::HEADER_BYTES + {32'd0, tbl_size[i+1]};
            if (merged > 64'hFFFF_FFFF)
                merged = 64'hFFFF_FFFF;
            tbl_size[i] = merged[31:0];
            for (int k = i + 1; k + 1 < tbl_count; k++)
            begin
                tbl_start[k] = tbl_start[k+1];
                tbl_size[k] = tbl_size[k+1];
                tbl_free[k] = tbl_free[k+1];
            end
            tbl_count--;
        end
        return r;
    endfunction

    // driver: bursts and gaps, new item loaded at the falling edge
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        heap_cmd_t c;
        if (!cmd_ch.valid || cmd_taken)
        begin
            cmd_taken = 0;
            if (gap_left > 0 || pending_cmds.size() == 0 || !rst_n)
            begin
                if (gap_left > 0)
                    gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else
            begin
                c = pending_cmds.pop_front();
                if (c.pick_block && tbl_count > 0)
                begin
                    c.release_address = tbl_start[c.sel % tbl_count] + ffha_pkg::HEADER_BYTES;
                    if (c.skew)
                        c.release_address += 8;
                end
                cur_cmd = c;
                cmd_ch.valid <= 1'b1;
                cmd_ch.command <= c.command;
                cmd_ch.request_bytes <= c.request_bytes;
                cmd_ch.release_address <= c.release_address;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver stalls: stretches of always-ready, random stalls and long holds
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold = 0;

    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 400);
        end
        else
            rx_mode_left--;
        if (rx_hold > 0)
        begin
            rx_hold--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_mode == 0)
            rsp_ch.ready <= 1'b1;
        else if (rx_mode == 1)
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        else
        begin
            if ($urandom_range(0, 15) == 0)
                rx_hold = $urandom_range(5, 25);
            rsp_ch.ready <= ($urandom_range(0, 1) == 0);
        end
    end

    // acceptance and result checking at the rising edge
    always @(posedge clk)
    begin
        heap_rsp_t e;
        if (rst_n && cmd_ch.valid && cmd_ch.ready && !cmd_taken)
        begin
            cmd_taken = 1;
            if (cur_cmd.command == ffha_pkg::CMD_ALLOC)
                e = do_allocate(cur_cmd.request_bytes);
            else
                e = do_release(cur_cmd.release_address);
            due_rsps.push_back(e);
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result addr %h status %0d", $realtime,
                         rsp_ch.granted_address, rsp_ch.status);
            end
            else
            begin
                e = due_rsps.pop_front();
                if (e.granted_address !== rsp_ch.granted_address)
                begin
                    errors++;
                    $display("%0t: granted_address expected %h actual %h", $realtime,
                             e.granted_address, rsp_ch.granted_address);
                end
                if (e.status !== rsp_ch.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             e.status, rsp_ch.status);
                end
                if (e.status != ffha_pkg::ST_OK)
                    n_refused++;
                else if (e.granted_address != 0)
                    n_grants++;
                else
                    n_release_ok++;
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        write_shadow_reg(idx, val);
    endtask

    task automatic add_alloc(logic [31:0] req);
        heap_cmd_t c;
        c = '{ffha_pkg::CMD_ALLOC, req, 32'd0, 0, 0, 0};
        pending_cmds.push_back(c);
    endtask

    task automatic add_release(logic [31:0] addr, bit pick, bit skew, int unsigned sel);
        heap_cmd_t c;
        c = '{ffha_pkg::CMD_RELEASE, $urandom, addr, pick, skew, sel};
        pending_cmds.push_back(c);
    endtask

    // wait until the block has drained, then let its longest item time pass
    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_cmds.size() != 0 || cmd_ch.valid || due_rsps.size() != 0);
        repeat (4 * ffha_pkg::MAX_BLOCKS + 40) @(posedge clk);
    endtask

    task automatic add_random(int n, int big_pct);
        int k;
        for (int j = 0; j < n; j++)
        begin
            k = $urandom_range(0, 99);
            if (k < 50)
                add_alloc($urandom_range(1, ($urandom_range(0, 9) == 0) ? 9000 : 300));
            else if (k < 50 + big_pct)
                add_alloc($urandom);
            else if (k < 52 + big_pct)
                add_alloc(32'd0);
            else if (k < 88)
                add_release(32'd0, 1, 0, $urandom);
            else if (k < 91)
                add_release(32'd0, 0, 0, 0);
            else if (k < 95)
                add_release(32'd0, 1, 1, $urandom);
            else
                add_release($urandom, 0, 0, 0);
        end
    endtask

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = ffha_pkg::CMD_ALLOC;
        cmd_ch.request_bytes = '0;
        cmd_ch.release_address = '0;
        rsp_ch.ready = 1'b0;
        base_reg = ffha_pkg::BASE_RESET;
        limit_reg = ffha_pkg::LIMIT_RESET;
        brk = ffha_pkg::BASE_RESET;
        tbl_count = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // empty table: break follows the base
        write_reg(ffha_pkg::CFG_BASE, 32'h2000_0000);

        add_alloc(32'd0);
        add_alloc(32'd1);
        add_alloc(32'hFFFF_FFFF);
        add_alloc(32'hFFFF_FFF8);
        add_alloc(32'h0020_0000);
        add_alloc(32'd100);
        add_alloc(32'd4000);
        add_alloc(32'd64);
        add_release(32'd0, 0, 0, 0);
        add_release(32'h1234_5678, 0, 0, 0);
        add_release(32'hFFFF_FFFF, 0, 0, 0);
        add_release(32'd0, 1, 0, 1);
        add_release(32'd0, 1, 0, 1);
        add_release(32'd0, 1, 0, 2);
        add_release(32'd0, 1, 0, 1);
        add_alloc(32'd8);
        add_alloc(32'd16);
        add_release(32'd0, 1, 1, 0);
        add_alloc(32'h000F_F000);
        add_alloc(32'd4072);
        drain();

        // table not empty: break stays put; window end saturates
        write_reg(ffha_pkg::CFG_BASE, 32'h0000_1000);
        write_reg(ffha_pkg::CFG_LIMIT, 32'hFFFF_FFFF);
        add_random(650, 5);
        drain();

        write_reg(ffha_pkg::CFG_BASE, 32'hFFFF_FFFF);
        write_reg(ffha_pkg::CFG_LIMIT, 32'd0);
        add_random(650, 3);
        drain();

        // window closed below the break: only reuse can succeed
        write_reg(ffha_pkg::CFG_BASE, 32'd0);
        write_reg(ffha_pkg::CFG_LIMIT, 32'd0);
        add_random(650, 3);
        drain();

        $display("covered %0d grants, %0d releases, %0d refusals over four register settings",
                 n_grants, n_release_ok, n_refused);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end
endmodule

### sim.f
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
sim/tb_first_fit_heap_allocator.sv
